// ===== rtl/rfmi_pkg.sv =====
package rfmi_pkg;

    localparam int FIELD_W   = 11;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    typedef enum logic [0:0] {
        REQ_TOGGLE = 1'b0,
        REQ_QUERY  = 1'b1
    } req_type_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_T_LEAF_RD,
        ST_T_LEAF_WR,
        ST_T_SIB_RD,
        ST_T_SIB_UPD,
        ST_Q_A,
        ST_Q_B,
        ST_Q_FIN
    } state_t;

endpackage

// ===== rtl/range_first_marked_index.sv =====
// toggle: reads and flips the leaf, then reads each sibling and rewrites the parent up to the root; no result
// query: walks the range level by level in ST_Q_A and ST_Q_B, then answers from ST_Q_FIN
// throughput: one request at a time, set by the single-port read of the span-minimum ram
// reset: synchronous, active low; afterwards a clearing pass writes none-marked
// to every node while s_tready stays low
module range_first_marked_index
    import rfmi_pkg::*;
#(
    parameter int NUM_POSITIONS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [10:0] position, [21:11] range_low, [32:22] range_high, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [10:0] first_marked, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] found
    output logic                 m_tuser
);

    localparam int TREE_NODES = 2 * NUM_POSITIONS;
    localparam int NW = $clog2(TREE_NODES);
    localparam int VW = $clog2(NUM_POSITIONS + 2);
    localparam int XW = (NW >= FIELD_W) ? NW + 1 : FIELD_W + 1;
    localparam logic [VW-1:0] NONE_MARK = VW'(NUM_POSITIONS + 1);
    localparam logic [XW-1:0] NPOS_X = XW'(NUM_POSITIONS);
    localparam logic [NW-1:0] LAST_NODE = NW'(TREE_NODES - 1);

    state_t state_reg, state_next;

    logic [NW:0]   a_reg, a_next;
    logic [NW:0]   b_reg, b_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic [VW-1:0] pos_reg, pos_next;
    logic          pend_reg, pend_next;
    logic [NW-1:0] clr_reg, clr_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic                found_reg, found_next;
    logic [FIELD_W-1:0]  first_reg, first_next;

    // span-minimum ram
    logic [VW-1:0] mem [TREE_NODES];
    logic [VW-1:0] rdata_reg;
    logic          wr_en;
    logic [NW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
    logic [NW-1:0] rd_addr;

    logic          accept;
    logic          is_query;
    logic [XW-1:0] pos_x, lo_x, hi_x;
    logic          pos_ok;
    logic          range_empty;
    logic [XW-1:0] leaf_x, qa_x, qb_x;
    logic [VW-1:0] fold_val;
    logic [VW-1:0] leaf_new;
    logic [VW-1:0] sib_min;
    logic [NW:0]   parent;
    logic          a_lt_b;
    logic          out_free;
    logic [XW-1:0] fold_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_query = (req_type_t'(s_tuser) == REQ_QUERY);

    assign pos_x  = XW'(s_tdata[FIELD_W-1:0]);
    assign lo_x   = (s_tdata[2*FIELD_W-1:FIELD_W] == '0) ? XW'(1)
                                                          : XW'(s_tdata[2*FIELD_W-1:FIELD_W]);
    assign hi_x   = (XW'(s_tdata[3*FIELD_W-1:2*FIELD_W]) > NPOS_X) ? NPOS_X
                                                          : XW'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
    assign pos_ok = (pos_x != '0) && (pos_x <= NPOS_X);
    assign range_empty = lo_x > hi_x;
    assign leaf_x = NPOS_X + pos_x - XW'(1);
    assign qa_x   = NPOS_X + lo_x - XW'(1);
    assign qb_x   = NPOS_X + hi_x;

    // fold the pending ram read into the running minimum
    assign fold_val = (pend_reg && (rdata_reg < cur_reg)) ? rdata_reg : cur_reg;
    assign fold_ext = XW'(fold_val);
    assign leaf_new = (rdata_reg == NONE_MARK) ? pos_reg : NONE_MARK;
    assign sib_min  = (rdata_reg < cur_reg) ? rdata_reg : cur_reg;
    assign parent   = a_reg >> 1;
    assign a_lt_b   = a_reg < b_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR: begin
                if (clr_reg == LAST_NODE) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (is_query) state_next = range_empty ? ST_Q_FIN : ST_Q_A;
                    else if (pos_ok) state_next = ST_T_LEAF_RD;
                end
            end
            ST_T_LEAF_RD: state_next = ST_T_LEAF_WR;
            ST_T_LEAF_WR: state_next = ST_T_SIB_RD;
            ST_T_SIB_RD:  state_next = ST_T_SIB_UPD;
            ST_T_SIB_UPD: begin
                state_next = (parent == (NW+1)'(1)) ? ST_IDLE : ST_T_SIB_RD;
            end
            ST_Q_A: state_next = a_lt_b ? ST_Q_B : ST_Q_FIN;
            ST_Q_B: state_next = ST_Q_A;
            ST_Q_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        pos_next      = pos_reg;
        pend_next     = 1'b0;
        clr_next      = clr_reg;
        found_next    = found_reg;
        first_next    = first_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = NONE_MARK;
        rd_addr       = '0;
        unique case (state_reg)
            ST_CLR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + NW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    cur_next = NONE_MARK;
                    if (is_query) begin
                        a_next = qa_x[NW:0];
                        b_next = qb_x[NW:0];
                    end else begin
                        a_next   = leaf_x[NW:0];
                        pos_next = pos_x[VW-1:0];
                    end
                end
            end
            ST_T_LEAF_RD: begin
                rd_addr = a_reg[NW-1:0];
            end
            ST_T_LEAF_WR: begin
                wr_en    = 1'b1;
                wr_addr  = a_reg[NW-1:0];
                wr_data  = leaf_new;
                cur_next = leaf_new;
            end
            ST_T_SIB_RD: begin
                rd_addr = a_reg[NW-1:0] ^ NW'(1);
            end
            ST_T_SIB_UPD: begin
                wr_en    = 1'b1;
                wr_addr  = parent[NW-1:0];
                wr_data  = sib_min;
                cur_next = sib_min;
                a_next   = parent;
            end
            ST_Q_A: begin
                cur_next = fold_val;
                if (a_lt_b && a_reg[0]) begin
                    rd_addr   = a_reg[NW-1:0];
                    a_next    = a_reg + (NW+1)'(1);
                    pend_next = 1'b1;
                end
            end
            ST_Q_B: begin
                cur_next = fold_val;
                if (b_reg[0]) begin
                    rd_addr   = b_reg[NW-1:0] - NW'(1);
                    pend_next = 1'b1;
                end
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
            end
            ST_Q_FIN: begin
                cur_next = fold_val;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    found_next    = (fold_val != NONE_MARK);
                    first_next    = (fold_val != NONE_MARK) ? fold_ext[FIELD_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        cur_reg   <= cur_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        first_reg <= first_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = M_TDATA_W'(first_reg);

    // an out-of-range toggle is dropped and leaves the block ready
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (is_query || pos_ok) |=> !s_tready)
        else $error("ready stayed high after an accepted transaction");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |-> !s_tready)
        else $error("ready raised during the clearing pass");

    a_no_node_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && state_reg != ST_CLR |-> wr_addr != '0)
        else $error("tree update wrote the unused node zero");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result carries a nonzero position");

endmodule
